### rtl/core/wpd_pkg.sv
// Package for the WAV PCM to PWM duty converter.
// Holds widths, header offsets, state encodings and shared structs.
// No dependencies; compiled first.
`default_nettype none

package wpd_pkg;

  localparam int BYTE_W   = 8;
  localparam int DUTY_W   = 11;
  localparam int FIELD_W  = 16;
  localparam int LEN_W    = 32;
  localparam int POS_W    = 6;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // Shared divider: dividend holds data length times eight
  localparam int DIV_NW   = LEN_W + 3;
  localparam int DIV_DW   = LEN_W;
  localparam int DIV_CW   = $clog2(DIV_NW);

  localparam int SAMPLE_W = 17;
  localparam int PROD_W   = DUTY_W + SAMPLE_W;

  localparam logic [DUTY_W-1:0] FULL_SCALE_RESET = 11'd1500;
  localparam logic [0:0]        REG_FULL_SCALE   = 1'b0;

  // Header byte offsets
  localparam logic [POS_W-1:0] POS_FMT_LO  = 6'd20;
  localparam logic [POS_W-1:0] POS_FMT_HI  = 6'd21;
  localparam logic [POS_W-1:0] POS_CH_LO   = 6'd22;
  localparam logic [POS_W-1:0] POS_CH_HI   = 6'd23;
  localparam logic [POS_W-1:0] POS_BITS_LO = 6'd34;
  localparam logic [POS_W-1:0] POS_BITS_HI = 6'd35;
  localparam logic [POS_W-1:0] POS_LEN_0   = 6'd40;
  localparam logic [POS_W-1:0] POS_LEN_1   = 6'd41;
  localparam logic [POS_W-1:0] POS_LEN_2   = 6'd42;
  localparam logic [POS_W-1:0] POS_LEN_3   = 6'd43;

  localparam logic [FIELD_W-1:0] FMT_PCM       = 16'd1;
  localparam logic [LEN_W-1:0]   MIN_FRAME_BITS = 32'd16;

  localparam logic KIND_DUTY   = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  typedef enum logic [2:0] {
    P_HEADER = 3'b001,
    P_DATA   = 3'b010,
    P_DONE   = 3'b100
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MOD  = 3'b010,
    S_CNT  = 3'b100
  } seq_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic              kind;
    logic [DUTY_W-1:0] duty;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

### rtl/core/wpd_byte_if.sv
// Byte stream channel into the converter: valid/ready plus byte and restart flag.
// Depends on wpd_pkg.
`default_nettype none

interface wpd_byte_if import wpd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              restart;

  modport source (output valid, output in_byte, output restart, input ready);
  modport sink   (input valid, input in_byte, input restart, output ready);
endinterface

`default_nettype wire

### rtl/core/wpd_duty_if.sv
// Result channel out of the converter: valid/ready plus kind, duty and last flag.
// Depends on wpd_pkg.
`default_nettype none

interface wpd_duty_if import wpd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              result_kind;
  logic [DUTY_W-1:0] duty;
  logic              last_sample;

  modport source (output valid, output result_kind, output duty, output last_sample,
                  input ready);
  modport sink   (input valid, input result_kind, input duty, input last_sample,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/wav_pcm_to_pwm_duty_core.sv
// Top level of the WAV PCM to PWM duty converter: header parser, frame counter,
// duty multiplier and result buffering. Depends on wpd_pkg, wpd_byte_if,
// wpd_duty_if, wpd_div and wpd_apb_regs.
//
//   channel   dir  handshake        payload
//   wav       in   valid/ready      in_byte[7:0], restart
//   pwm       out  valid/ready      result_kind, duty[10:0], last_sample
//   apb       in   psel/penable     paddr[2:0], pwdata/prdata[31:0], pready = 1
//
// Every byte takes one cycle, except header byte 43 of an accepted format: the
// shared divider first takes the remainder of frame bytes by channels and, if it
// is zero, then the frame count; the byte input is held off meanwhile.
// A result waits in the output register, a second one in a skid register;
// input also stalls while the skid register is full. Synchronous reset clears
// parse state and sets full scale to 1500; no clearing pass is needed.
`default_nettype none

module wav_pcm_to_pwm_duty_core import wpd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  wpd_byte_if.sink               wav,
  wpd_duty_if.source             pwm,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  logic [DUTY_W-1:0] full_scale;

  wpd_apb_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .full_scale (full_scale)
  );

  // parse state
  seq_t               seq, seq_next;
  phase_t             phase, phase_next;
  logic [POS_W-1:0]   pos, pos_next;
  logic [FIELD_W-1:0] fmt, fmt_next;
  logic [FIELD_W-1:0] chans, chans_next;
  logic [FIELD_W-1:0] bits, bits_next;
  logic [LEN_W-1:0]   dlen, dlen_next;
  logic [LEN_W-1:0]   frames, frames_next;
  logic [LEN_W-1:0]   offset, offset_next;
  logic [BYTE_W-1:0]  lo, lo_next;
  logic [LEN_W-1:0]   fbits;

  // divider
  logic              div_start;
  logic [DIV_NW-1:0] div_dividend;
  logic [DIV_DW-1:0] div_divisor;
  div_stat_t         div_stat;
  logic [DIV_NW-1:0] div_quo;
  logic [DIV_DW-1:0] div_rem;

  wpd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // results
  logic emit;
  res_t emit_res;
  logic out_valid, skid_valid;
  res_t out_res, skid_res;

  logic                accept;
  logic [BYTE_W-1:0]   b;
  logic [LEN_W-4:0]    fbytes;
  logic                hdr_ok;
  logic [SAMPLE_W-1:0] shifted;
  logic [PROD_W-1:0]   prod;
  logic [LEN_W-1:0]    off_inc;

  assign accept  = wav.valid && wav.ready;
  assign b       = wav.in_byte;
  assign fbytes  = fbits[LEN_W-1:3];
  assign hdr_ok  = (fmt == FMT_PCM) && (chans != '0) && (fbits >= MIN_FRAME_BITS);
  // signed sample plus 0x10000 is the raw word with its inverted sign bit added as bit 16
  assign shifted = {~b[BYTE_W-1], b, lo};
  assign prod    = {{SAMPLE_W{1'b0}}, full_scale} * {{DUTY_W{1'b0}}, shifted};
  assign off_inc = offset + 1'b1;

  always_ff @(posedge clk) begin
    fbits <= LEN_W'(chans) * LEN_W'(bits);
  end

  always_comb begin
    seq_next     = seq;
    phase_next   = phase;
    pos_next     = pos;
    fmt_next     = fmt;
    chans_next   = chans;
    bits_next    = bits;
    dlen_next    = dlen;
    frames_next  = frames;
    offset_next  = offset;
    lo_next      = lo;
    emit         = 1'b0;
    emit_res     = '{kind: KIND_REJECT, duty: '0, last: 1'b0};
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;

    unique case (seq)
      S_IDLE: begin
        if (accept) begin
          if (wav.restart) begin
            // this byte is header byte 0, which carries nothing
            phase_next  = P_HEADER;
            pos_next    = POS_W'(1);
            fmt_next    = '0;
            chans_next  = '0;
            bits_next   = '0;
            dlen_next   = '0;
            frames_next = '0;
            offset_next = '0;
            lo_next     = '0;
          end else begin
            unique case (phase)
              P_HEADER: begin
                unique case (pos)
                  POS_FMT_LO:  fmt_next   = {fmt[15:8], b};
                  POS_FMT_HI:  fmt_next   = {b, fmt[7:0]};
                  POS_CH_LO:   chans_next = {chans[15:8], b};
                  POS_CH_HI:   chans_next = {b, chans[7:0]};
                  POS_BITS_LO: bits_next  = {bits[15:8], b};
                  POS_BITS_HI: bits_next  = {b, bits[7:0]};
                  POS_LEN_0:   dlen_next  = {dlen[31:8], b};
                  POS_LEN_1:   dlen_next  = {dlen[31:16], b, dlen[7:0]};
                  POS_LEN_2:   dlen_next  = {dlen[31:24], b, dlen[15:0]};
                  POS_LEN_3:   dlen_next  = {b, dlen[23:0]};
                  default: ;
                endcase
                if (pos == POS_LEN_3) begin
                  if (hdr_ok) begin
                    div_start    = 1'b1;
                    div_dividend = {{(DIV_NW-LEN_W+3){1'b0}}, fbytes};
                    div_divisor  = {{(DIV_DW-FIELD_W){1'b0}}, chans};
                    seq_next     = S_MOD;
                  end else begin
                    emit       = 1'b1;
                    phase_next = P_DONE;
                  end
                end else begin
                  pos_next = pos + 1'b1;
                end
              end
              P_DATA: begin
                if (offset == '0) begin
                  lo_next = b;
                end else if (offset == LEN_W'(1)) begin
                  emit     = 1'b1;
                  emit_res = '{kind: KIND_DUTY, duty: prod[PROD_W-1:SAMPLE_W],
                               last: (frames == LEN_W'(1))};
                end
                if (off_inc >= {3'b000, fbytes}) begin
                  offset_next = '0;
                  frames_next = frames - 1'b1;
                  if (frames == LEN_W'(1)) begin
                    phase_next = P_DONE;
                  end
                end else begin
                  offset_next = off_inc;
                end
              end
              P_DONE: ;
              default: phase_next = P_DONE;
            endcase
          end
        end
      end
      S_MOD: begin
        if (div_stat.done) begin
          if (div_rem != '0) begin
            emit       = 1'b1;
            phase_next = P_DONE;
            seq_next   = S_IDLE;
          end else begin
            div_start    = 1'b1;
            div_dividend = {dlen, 3'b000};
            div_divisor  = fbits;
            seq_next     = S_CNT;
          end
        end
      end
      S_CNT: begin
        if (div_stat.done) begin
          frames_next = div_quo[LEN_W-1:0];
          offset_next = '0;
          phase_next  = (div_quo == '0) ? P_DONE : P_DATA;
          seq_next    = S_IDLE;
        end
      end
      default: seq_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq    <= S_IDLE;
      phase  <= P_HEADER;
      pos    <= '0;
      fmt    <= '0;
      chans  <= '0;
      bits   <= '0;
      dlen   <= '0;
      frames <= '0;
      offset <= '0;
      lo     <= '0;
    end else begin
      seq    <= seq_next;
      phase  <= phase_next;
      pos    <= pos_next;
      fmt    <= fmt_next;
      chans  <= chans_next;
      bits   <= bits_next;
      dlen   <= dlen_next;
      frames <= frames_next;
      offset <= offset_next;
      lo     <= lo_next;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (emit) begin
      if (!out_valid || pwm.ready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_valid && pwm.ready) begin
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (!out_valid || pwm.ready) begin
        out_res <= emit_res;
      end else begin
        skid_res <= emit_res;
      end
    end else if (out_valid && pwm.ready && skid_valid) begin
      out_res <= skid_res;
    end
  end

  assign wav.ready       = (seq == S_IDLE) && !skid_valid;
  assign pwm.valid       = out_valid;
  assign pwm.result_kind = out_res.kind;
  assign pwm.duty        = out_res.duty;
  assign pwm.last_sample = out_res.last;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    (seq == S_IDLE) |-> !div_stat.busy)
    else $error("divider busy while sequencer idle");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (seq == S_MOD || seq == S_CNT))
    else $error("divider finished outside a wait state");

  a_data_has_frames: assert property (@(posedge clk) disable iff (rst)
    (phase == P_DATA) |-> (frames != '0))
    else $error("data phase with no frames left");

endmodule

`default_nettype wire

### rtl/core/wpd_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Used for the channel divisibility check and the frame count. Depends on wpd_pkg.
`default_nettype none

module wpd_div import wpd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DIV_NW-1:0] dividend,
  input  wire logic [DIV_DW-1:0] divisor,
  output div_stat_t              stat,
  output logic      [DIV_NW-1:0] quotient,
  output logic      [DIV_DW-1:0] remainder
);

  logic [DIV_NW-1:0] quo;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dvs;
  logic [DIV_CW-1:0] cnt;
  logic              busy;
  logic              done;

  logic [DIV_DW:0]   shifted;
  logic [DIV_DW+1:0] diff;

  assign shifted = {rem, quo[DIV_NW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CW'(DIV_NW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      // keep the difference when it did not borrow
      if (!diff[DIV_DW+1]) begin
        rem <= diff[DIV_DW-1:0];
        quo <= {quo[DIV_NW-2:0], 1'b1};
      end else begin
        rem <= shifted[DIV_DW-1:0];
        quo <= {quo[DIV_NW-2:0], 1'b0};
      end
    end
  end

  assign stat      = '{busy: busy, done: done};
  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

### rtl/core/wpd_apb_regs.sv
// APB register file: the PWM full-scale register.
// Depends on wpd_pkg.
`default_nettype none

module wpd_apb_regs import wpd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output logic      [DUTY_W-1:0] full_scale
);

  logic hit;

  assign hit    = (paddr[APB_AW-1:2] == REG_FULL_SCALE);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale <= FULL_SCALE_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      full_scale <= pwdata[DUTY_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = {{(APB_DW-DUTY_W){1'b0}}, full_scale};
    end
  end

endmodule

`default_nettype wire
